// File: src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed field widths of the sliding-window minimum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int unsigned SAMPLE_BITS = 32;
    localparam int unsigned WLEN_BITS   = 11;
    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 11'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_POP,
        ST_LOAD
    } swm_state_t;

endpackage

// File: src/sliding_window_minimum_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_minimum_unit
// Streaming minimum over the last window_length samples, kept as a ring of
// samples and a monotonic deque of candidate minima, both in synchronous RAM.
//
//   channel   direction  payload                          accepted when
//   s_axis    in         tdata: sample, tuser: restart    tvalid & tready
//   m_axis    out        tdata: window_min                tvalid & tready
//   cfg       in         data: window_length              valid & ready
//
// An item passes through IDLE, RETIRE and POP; RETIRE repeats while further
// samples leave the window, and each dropped candidate adds a pass through
// POP and, while one is left, LOAD (RAM read latency on the deque back).
// Reset clears state, pointers, counts and valid; RAM contents need no clearing.
// A result waits in the output register; a new item is taken meanwhile and,
// if it emits, stalls at its own push while that register is still full.
// ----------------------------------------------------------------------------
module sliding_window_minimum_unit #(
    parameter int unsigned WINDOW_MAX   = 1024,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [swm_pkg::SAMPLE_BITS-1:0]     s_axis_tdata,  // [31:0] sample
    input  logic [0:0]                          s_axis_tuser,  // [0] restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [swm_pkg::SAMPLE_BITS-1:0]     m_axis_tdata,  // [31:0] window_min
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swm_pkg::WLEN_BITS-1:0]       cfg_data
);
    import swm_pkg::*;

    localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
    localparam int unsigned EW = (CW > WLEN_BITS) ? CW : WLEN_BITS;
    localparam int unsigned SW = SAMPLE_WIDTH;

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(WINDOW_MAX))
        begin
            sum = sum - (CW+1)'(WINDOW_MAX);
        end
        return AW'(sum);
    endfunction

    logic [SW-1:0] hist_mem [WINDOW_MAX];
    logic [SW-1:0] cand_mem [WINDOW_MAX];

    swm_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] held_reg, held_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [WLEN_BITS-1:0] wlen_reg;
    logic out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_data_reg, out_data_next;
    logic [SW-1:0] x_reg, x_next;
    logic [SW-1:0] front_val_reg, front_val_next;
    logic [SW-1:0] back_val_reg, back_val_next;

    logic [SW-1:0] hist_q, cand_q;
    logic [AW-1:0] hist_raddr, cand_raddr;
    logic          mem_we;
    logic [AW-1:0] hist_waddr, cand_waddr;

    logic [EW-1:0] wlen_ext;
    logic [CW-1:0] w_eff;
    logic          out_busy;
    logic          emit;

    always_comb
    begin
        wlen_ext = EW'(wlen_reg);
        if (wlen_ext == '0)
        begin
            w_eff = CW'(1);
        end
        else if (wlen_ext > EW'(WINDOW_MAX))
        begin
            w_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CW'(wlen_ext);
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign emit          = ((held_reg + CW'(1)) >= w_eff);
    assign hist_waddr    = ptr_add(head_reg, held_reg);
    assign cand_waddr    = ptr_add(front_reg, count_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        held_next      = held_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        x_next         = x_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        hist_raddr     = head_reg;
        cand_raddr     = ptr_add(front_reg, CW'(1));
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x_next = SW'(s_axis_tdata);
                    if (s_axis_tuser[0])
                    begin
                        head_next  = '0;
                        held_next  = '0;
                        front_next = '0;
                        count_next = '0;
                    end
                    state_next = ST_RETIRE;
                end
            end
            ST_RETIRE:
            begin
                if (held_reg >= w_eff)
                begin
                    if (count_reg != '0 && hist_q == front_val_reg)
                    begin
                        front_next     = ptr_add(front_reg, CW'(1));
                        count_next     = count_reg - CW'(1);
                        front_val_next = cand_q;
                    end
                    head_next  = ptr_add(head_reg, CW'(1));
                    held_next  = held_reg - CW'(1);
                    hist_raddr = head_next;
                    cand_raddr = ptr_add(front_next, CW'(1));
                    if (held_next < w_eff)
                    begin
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (count_reg != '0 && back_val_reg > x_reg)
                begin
                    // drop the back candidate, fetch the new back if one is left
                    count_next = count_reg - CW'(1);
                    cand_raddr = ptr_add(front_reg,
                                         (count_reg > CW'(1)) ? count_reg - CW'(2) : '0);
                    if (count_reg > CW'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
                else if (!(emit && out_busy))
                begin
                    mem_we        = 1'b1;
                    held_next     = held_reg + CW'(1);
                    count_next    = count_reg + CW'(1);
                    back_val_next = x_reg;
                    if (count_reg == '0)
                    begin
                        front_val_next = x_reg;
                    end
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = SAMPLE_BITS'((count_reg == '0) ? x_reg
                                                                        : front_val_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                back_val_next = cand_q;
                state_next    = ST_POP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            wlen_reg      <= WLEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                wlen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[hist_waddr] <= x_reg;
        end
        hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cand_mem[cand_waddr] <= x_reg;
        end
        cand_q <= cand_mem[cand_raddr];
    end

endmodule
